@@ design/kmdt_pkg.sv @@
// kmdt_pkg: shared types, constants and key functions of the keypad debounce tracker
// no dependencies; imported by kmdt_front, kmdt_back and the top level
package kmdt_pkg;

	localparam int SLOTS = 4;
	localparam int KEY_W = 7;
	localparam int CNT_W = 8;
	localparam int CODE_W = 8;

	localparam int MQ_DEPTH = 2;
	localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
	localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

	localparam int OQ_DEPTH = 2;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam int HELD_N = 3;
	localparam int HELD_W = $clog2(HELD_N + 1);

	localparam logic [3:0]        ROW_MAX   = 4'd8;
	localparam logic [2:0]        COL_MAX   = 3'd5;
	localparam logic [CNT_W-1:0]  CNT_MAX   = 8'd255;
	localparam logic [CNT_W-1:0]  DEB_RESET = 8'd3;
	localparam logic [CODE_W-1:0] REL_OFS   = 8'd100;
	localparam logic [KEY_W-1:0]  KEY_NONE  = 7'd0;

	typedef struct packed {
		logic [3:0] row;
		logic [2:0] col;
		logic       pressed;
	} in_word_t;

	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic [KEY_W-1:0]  held_key_a;
		logic [KEY_W-1:0]  held_key_b;
		logic [KEY_W-1:0]  held_key_c;
	} out_word_t;

	// classified reading, as queued between front and back
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] code_key;
		logic             down;
	} cls_word_t;

	typedef struct packed {
		logic      valid;
		cls_word_t word;
	} mq_head_t;

	function automatic logic [KEY_W-1:0] key_of(input logic [3:0] row, input logic [2:0] col);
		logic [KEY_W-1:0] rinv;
		rinv = KEY_W'(ROW_MAX - row);
		return KEY_W'(rinv * KEY_W'(10)) + KEY_W'(col) + KEY_W'(1);
	endfunction

	// keys 42..46, 53..56, 63..66, 73..76, 83..86 move down by one
	function automatic logic [KEY_W-1:0] remap_key(input logic [KEY_W-1:0] k);
		logic dec;
		dec = (k > 7'd41 && k < 7'd47) || (k > 7'd52 && k < 7'd57) ||
		      (k > 7'd62 && k < 7'd67) || (k > 7'd72 && k < 7'd77) ||
		      (k > 7'd82 && k < 7'd87);
		return dec ? k - KEY_W'(1) : k;
	endfunction

endpackage

@@ design/keypad_multikey_debounce_tracker.sv @@
// keypad_multikey_debounce_tracker: top level, front classifier and back slot tracker
// depends on kmdt_pkg, kmdt_front, kmdt_back
//
//   channel   handshake              word
//   input     push / full            item   (row, col, pressed)
//   result    pop / empty            result (event_code, held_key_a..c)
//   config    cfg_valid / cfg_ready  cfg_data (debounce_count)
//
// one reading per cycle sustained while the result queue has room; a result
// passes the front queue, then the slot update, before it shows on the result ports
// the slot table is read and written back in the same cycle, which sets the rate
// reset clears the slot table, both queues and loads debounce_count with 3
// a stalled result queue fills the front queue, then full rises
module keypad_multikey_debounce_tracker import kmdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  in_word_t         item,
	input  logic             push,
	output logic             full,
	output out_word_t        result,
	output logic             empty,
	input  logic             pop,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	mq_head_t q_head;
	logic     q_pop;

	kmdt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.q_head (q_head),
		.q_pop  (q_pop)
	);

	kmdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("queue popped while empty");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_head.valid && !q_pop |=> q_head.valid && $stable(q_head.word))
		else $error("queue head changed without pop");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!q_head.valid && !(push && !full) |=> !q_head.valid)
		else $error("queue filled without accepted word");

	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.event_code != '0)
		else $error("result word with zero event code");

endmodule

@@ design/kmdt_front.sv @@
// kmdt_front: accepts readings, range-checks and classifies them into key numbers
// feeds a two-entry queue toward the back end; depends on kmdt_pkg
module kmdt_front import kmdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_word_t item,
	input  logic     push,
	output logic     full,
	output mq_head_t q_head,
	input  logic     q_pop
);

	cls_word_t             mq_q [MQ_DEPTH];
	logic [MQ_PTR_W-1:0]   rd_ptr_q;
	logic [MQ_PTR_W-1:0]   wr_ptr_q;
	logic [MQ_CNT_W-1:0]   cnt_q;
	logic                  in_range;
	logic                  enq;
	cls_word_t             cls;

	assign full     = (cnt_q == MQ_CNT_W'(MQ_DEPTH));
	assign in_range = (item.row <= ROW_MAX) && (item.col <= COL_MAX);
	assign enq      = push && !full && in_range;

	always_comb begin
		cls.key      = key_of(item.row, item.col);
		cls.code_key = remap_key(cls.key);
		cls.down     = item.pressed;
	end

	assign q_head.valid = (cnt_q != '0);
	assign q_head.word  = mq_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq)
				wr_ptr_q <= wr_ptr_q + MQ_PTR_W'(1);
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + MQ_PTR_W'(1);
			cnt_q <= cnt_q + MQ_CNT_W'(enq) - MQ_CNT_W'(q_pop);
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (enq)
			mq_q[wr_ptr_q] <= cls;
	end

endmodule

@@ design/kmdt_back.sv @@
// kmdt_back: slot table update, event generation and two-entry result queue
// holds the debounce_count register; depends on kmdt_pkg
module kmdt_back import kmdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,
	input  mq_head_t          q_head,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output out_word_t         result
);

	logic [CNT_W-1:0]    deb_q;
	logic [KEY_W-1:0]    slot_key_q [SLOTS];
	logic [CNT_W-1:0]    slot_cnt_q [SLOTS];
	logic [KEY_W-1:0]    nxt_key [SLOTS];
	logic [CNT_W-1:0]    nxt_cnt [SLOTS];
	logic                match [SLOTS];
	logic                valid [SLOTS];
	logic [KEY_W-1:0]    held [HELD_N];
	logic [HELD_W-1:0]   nheld;
	logic [CNT_W-1:0]    thr;
	logic                found;
	logic                claimed;
	logic                press_hit;
	logic                rel_hit;
	logic                fire;
	logic                res_push;
	logic                res_pop;
	out_word_t           res_word;
	cls_word_t           w;

	out_word_t           oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;

	assign cfg_ready = 1'b1;
	assign w         = q_head.word;
	assign thr       = (deb_q == '0) ? CNT_W'(1) : deb_q;

	always_comb begin
		nxt_key   = slot_key_q;
		nxt_cnt   = slot_cnt_q;
		found     = 1'b0;
		claimed   = 1'b0;
		press_hit = 1'b0;
		rel_hit   = 1'b0;
		nheld     = '0;
		for (int h = 0; h < HELD_N; h++)
			held[h] = KEY_NONE;
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (slot_key_q[i] == w.key);
			valid[i] = (slot_cnt_q[i] >= thr);
			if (w.down && match[i]) begin
				found = 1'b1;
				if (slot_cnt_q[i] != CNT_MAX) begin
					nxt_cnt[i] = slot_cnt_q[i] + CNT_W'(1);
					if (slot_cnt_q[i] + CNT_W'(1) == thr)
						press_hit = 1'b1;
				end
			end else if (!w.down && match[i] && valid[i]) begin
				rel_hit    = 1'b1;
				nxt_key[i] = KEY_NONE;
				nxt_cnt[i] = '0;
			end else if (valid[i]) begin
				if (nheld != HELD_W'(HELD_N)) begin
					held[nheld[HELD_W-1:0]] = remap_key(slot_key_q[i]);
					nheld = nheld + HELD_W'(1);
				end
			end
		end
		// untracked press takes the first idle slot
		for (int i = 0; i < SLOTS; i++) begin
			if (w.down && !found && !claimed && slot_cnt_q[i] == '0) begin
				nxt_key[i] = w.key;
				claimed    = 1'b1;
			end
		end
	end

	always_comb begin
		res_word.event_code = rel_hit ? CODE_W'(w.code_key) + REL_OFS : CODE_W'(w.code_key);
		res_word.held_key_a = held[0];
		res_word.held_key_b = held[1];
		res_word.held_key_c = held[2];
	end

	assign empty    = (oq_cnt_q == '0);
	assign res_pop  = pop && !empty;
	assign fire     = q_head.valid && ((oq_cnt_q != OQ_CNT_W'(OQ_DEPTH)) || res_pop);
	assign q_pop    = fire;
	assign res_push = fire && (press_hit || rel_hit);
	assign result   = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= DEB_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				slot_key_q[i] <= KEY_NONE;
				slot_cnt_q[i] <= '0;
			end
			oq_rd_q  <= '0;
			oq_wr_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				deb_q <= cfg_data;
			if (fire) begin
				slot_key_q <= nxt_key;
				slot_cnt_q <= nxt_cnt;
			end
			if (res_push)
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			if (res_pop)
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(res_push) - OQ_CNT_W'(res_pop);
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (res_push)
			oq_q[oq_wr_q] <= res_word;
	end

endmodule

@@ tb/sv/keypad_multikey_debounce_tracker_tb.sv @@
// keypad_multikey_debounce_tracker_tb: self-checking bench for the keypad debounce tracker
// depends on kmdt_pkg and keypad_multikey_debounce_tracker; runs a table, then random key traffic
// with random idling on both queue sides, checked against a slot-table predictor
`timescale 1ns / 100ps

module keypad_multikey_debounce_tracker_tb;
	import kmdt_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int POOL_N       = 6;
	localparam int DIR_N        = 25;

	typedef struct packed {
		in_word_t  rd;
		logic      typed;
		out_word_t res;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{'{4'd8, 3'd0, 1'b1}, 1'b0, '0},
		'{'{4'd8, 3'd0, 1'b1}, 1'b0, '0},
		'{'{4'd8, 3'd0, 1'b1}, 1'b0, '0},
		'{'{4'd8, 3'd0, 1'b1}, 1'b1, '{8'd1, 7'd0, 7'd0, 7'd0}},
		'{'{4'd0, 3'd5, 1'b1}, 1'b0, '0},
		'{'{4'd0, 3'd5, 1'b1}, 1'b0, '0},
		'{'{4'd0, 3'd5, 1'b1}, 1'b0, '0},
		'{'{4'd0, 3'd5, 1'b1}, 1'b1, '{8'd85, 7'd1, 7'd0, 7'd0}},
		// off-matrix readings
		'{'{4'd15, 3'd7, 1'b1}, 1'b0, '0},
		'{'{4'd0, 3'd6, 1'b1}, 1'b0, '0},
		// release before the press is debounced
		'{'{4'd4, 3'd2, 1'b1}, 1'b0, '0},
		'{'{4'd4, 3'd2, 1'b0}, 1'b0, '0},
		'{'{4'd8, 3'd0, 1'b0}, 1'b1, '{8'd101, 7'd85, 7'd0, 7'd0}},
		'{'{4'd3, 3'd3, 1'b1}, 1'b0, '0},
		'{'{4'd4, 3'd2, 1'b1}, 1'b0, '0},
		'{'{4'd3, 3'd3, 1'b1}, 1'b0, '0},
		'{'{4'd2, 3'd4, 1'b1}, 1'b0, '0},
		'{'{4'd2, 3'd4, 1'b1}, 1'b0, '0},
		// table full, new key dropped
		'{'{4'd1, 3'd1, 1'b1}, 1'b0, '0},
		'{'{4'd4, 3'd2, 1'b1}, 1'b0, '0},
		'{'{4'd4, 3'd2, 1'b1}, 1'b1, '{8'd42, 7'd85, 7'd0, 7'd0}},
		'{'{4'd3, 3'd3, 1'b1}, 1'b0, '0},
		'{'{4'd3, 3'd3, 1'b1}, 1'b1, '{8'd53, 7'd85, 7'd42, 7'd0}},
		'{'{4'd2, 3'd4, 1'b1}, 1'b0, '0},
		'{'{4'd2, 3'd4, 1'b1}, 1'b1, '{8'd64, 7'd53, 7'd85, 7'd42}}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	in_word_t         item = '0;
	logic             push = 1'b0;
	logic             full;
	out_word_t        result;
	logic             empty;
	logic             pop = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = DEB_RESET;

	// predictor state
	logic [KEY_W-1:0] key_tab [SLOTS] = '{default: KEY_NONE};
	logic [CNT_W-1:0] cnt_tab [SLOTS] = '{default: '0};
	logic [CNT_W-1:0] deb_reg = DEB_RESET;

	out_word_t pending_events [$];
	in_word_t  pool [POOL_N];
	int        tx_run = 0;
	int        rx_run = 0;
	int        n_items = 0;
	int        n_results = 0;
	int        n_fail = 0;
	logic      hold_start = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	keypad_multikey_debounce_tracker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push      (push),
		.full      (full),
		.result    (result),
		.empty     (empty),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	function automatic int idle_len(inout int run_left);
		int r;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			run_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [KEY_W-1:0] shift_key(input logic [KEY_W-1:0] k);
		return (k inside {[42:46], [53:56], [63:66], [73:76], [83:86]}) ? k - KEY_W'(1) : k;
	endfunction

	function automatic in_word_t key_word(input logic [KEY_W-1:0] key, input logic down);
		in_word_t w;
		w.row = 4'(8 - (int'(key) - 1) / 10);
		w.col = 3'((int'(key) - 1) % 10);
		w.pressed = down;
		return w;
	endfunction

	function automatic logic track_reading(input in_word_t w, output out_word_t r);
		logic [CNT_W-1:0] thr;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] held [HELD_N];
		logic             hit;
		logic             valid;
		int               nh;
		r = '0;
		held = '{default: KEY_NONE};
		hit = 1'b0;
		nh = 0;
		if (w.row > ROW_MAX || w.col > COL_MAX) return 1'b0;
		thr = (deb_reg == '0) ? CNT_W'(1) : deb_reg;
		k = KEY_W'((8 - int'(w.row)) * 10 + int'(w.col) + 1);
		for (int i = 0; i < SLOTS; i++) begin
			valid = (cnt_tab[i] >= thr);
			if (w.pressed && key_tab[i] == k) begin
				hit = 1'b1;
				if (cnt_tab[i] != CNT_MAX) begin
					cnt_tab[i] = cnt_tab[i] + CNT_W'(1);
					if (cnt_tab[i] == thr) r.event_code = CODE_W'(shift_key(k));
				end
			end else if (!w.pressed && key_tab[i] == k && valid) begin
				r.event_code = CODE_W'(shift_key(k)) + REL_OFS;
				key_tab[i] = KEY_NONE;
				cnt_tab[i] = '0;
			end else if (valid && nh < HELD_N) begin
				held[nh] = shift_key(key_tab[i]);
				nh++;
			end
		end
		if (w.pressed && !hit) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (cnt_tab[i] == '0) begin
					key_tab[i] = k;
					break;
				end
			end
		end
		r.held_key_a = held[0];
		r.held_key_b = held[1];
		r.held_key_c = held[2];
		return r.event_code != '0;
	endfunction

	task automatic send_item(input in_word_t w, input logic typed, input out_word_t typed_res);
		out_word_t r;
		logic      got;
		int        gap;
		gap = idle_len(tx_run);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		push <= 1'b1;
		do @(posedge clk); while (full);
		n_items++;
		got = track_reading(w, r);
		if (typed) pending_events.push_back(typed_res);
		else if (got) pending_events.push_back(r);
	endtask

	task automatic set_debounce(input logic [CNT_W-1:0] v);
		push <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		deb_reg = v;
	endtask

	// mostly presses and releases of a few keys, tracked keys kept in the mix
	task automatic run_random(input int n);
		in_word_t w;
		int       done;
		int       issued;
		done = 0;
		issued = 0;
		while (done < n) begin
			if (issued % 40 == 0) begin
				for (int i = 0; i < POOL_N; i++) begin
					if (i < SLOTS && key_tab[i] != KEY_NONE) begin
						pool[i] = key_word(key_tab[i], 1'b1);
					end else begin
						pool[i].row = 4'($urandom_range(0, 8));
						pool[i].col = 3'($urandom_range(0, 5));
					end
				end
			end
			if ($urandom_range(0, 9) == 0) begin
				w.row = 4'($urandom_range(0, 15));
				w.col = 3'($urandom_range(0, 7));
				w.pressed = 1'($urandom_range(0, 1));
			end else begin
				w = pool[$urandom_range(0, POOL_N - 1)];
				w.pressed = ($urandom_range(0, 3) != 0);
			end
			send_item(w, 1'b0, '0);
			issued++;
			if (w.row <= ROW_MAX && w.col <= COL_MAX) done++;
		end
	endtask

	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_side
		out_word_t want;
		logic      took;
		int        stall;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			took = pop && !empty;
			if (took) begin
				n_results++;
				if (pending_events.size() == 0) begin
					$error("result word with nothing pending: event_code %0d", result.event_code);
					n_fail++;
				end else begin
					want = pending_events.pop_front();
					if (result.event_code !== want.event_code) begin
						$error("event_code: expected %0d, got %0d", want.event_code,
							result.event_code);
						n_fail++;
					end
					if (result.held_key_a !== want.held_key_a) begin
						$error("held_key_a: expected %0d, got %0d", want.held_key_a,
							result.held_key_a);
						n_fail++;
					end
					if (result.held_key_b !== want.held_key_b) begin
						$error("held_key_b: expected %0d, got %0d", want.held_key_b,
							result.held_key_b);
						n_fail++;
					end
					if (result.held_key_c !== want.held_key_c) begin
						$error("held_key_c: expected %0d, got %0d", want.held_key_c,
							result.held_key_c);
						n_fail++;
					end
				end
			end
			if (took && stall == 0) stall = idle_len(rx_run);
			if (hold_start) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_start = 1'b0;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		in_word_t held_one;
		in_word_t sat_key;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_item(DIR_TAB[i].rd, DIR_TAB[i].typed, DIR_TAB[i].res);

		set_debounce(CNT_W'(1));
		run_random(150);
		hold_start = 1'b1;
		run_random(250);

		set_debounce('0);
		run_random(300);

		// free every slot so the saturation pair can be tracked
		for (int i = 0; i < SLOTS; i++)
			if (cnt_tab[i] != '0) send_item(key_word(key_tab[i], 1'b0), 1'b0, '0);

		set_debounce(CNT_MAX);
		held_one.row = 4'($urandom_range(5, 8));
		held_one.col = 3'($urandom_range(0, 5));
		held_one.pressed = 1'b1;
		sat_key.row = 4'($urandom_range(0, 3));
		sat_key.col = 3'($urandom_range(0, 5));
		sat_key.pressed = 1'b1;
		repeat (256) send_item(held_one, 1'b0, '0);
		repeat (258) send_item(sat_key, 1'b0, '0);
		sat_key.pressed = 1'b0;
		held_one.pressed = 1'b0;
		send_item(sat_key, 1'b0, '0);
		send_item(held_one, 1'b0, '0);

		set_debounce(CNT_W'($urandom_range(2, 12)));
		run_random(350);
		set_debounce(CNT_W'($urandom_range(2, 12)));
		run_random(350);

		push <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d key readings, checked %0d event words", n_items, n_results);
		$display("debounce run at reset value, 1, 0, 255 with saturation, two mid values");
		if (n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/kmdt_pkg.sv
design/kmdt_front.sv
design/kmdt_back.sv
design/keypad_multikey_debounce_tracker.sv
tb/sv/keypad_multikey_debounce_tracker_tb.sv
